// File: hw/rtl/ldq_pkg.sv
// ============================================================================
// ldq_pkg: shared types and codes for the linked deque
// Holds the request and response payload structures, the command and status
// codes and the controller command group used between the two halves.
// ============================================================================
package ldq_pkg;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int HANDLE_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    // Width of one group of the lowest-free-slot search tree.
    localparam int GROUP_W  = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [VALUE_W-1:0]  value;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] new_handle;
        logic [VALUE_W-1:0]  popped_value;
        logic [COUNT_W-1:0]  count;
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
    } rsp_t;

    // Step strobes from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic resolve;
        logic commit;
    } ctrl_cmd_t;

endpackage

// File: hw/rtl/ldq_ram.sv
// ============================================================================
// ldq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// while no read is requested.
// ============================================================================
module ldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/ldq_free_find.sv
// ============================================================================
// ldq_free_find: lowest free slot search
// A two-level registered tree: the first level encodes each group of slots,
// the second picks the lowest group that has a free slot.
// ============================================================================
module ldq_free_find #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [SLOT_COUNT-1:0]         in_use,
    output logic [$clog2(SLOT_COUNT)-1:0] lowest
);

    localparam int AW  = $clog2(SLOT_COUNT);
    localparam int GW  = ldq_pkg::GROUP_W;
    localparam int NG  = (SLOT_COUNT + GW - 1) / GW;
    localparam int GIW = $clog2(GW);
    localparam int GSW = (NG > 1) ? $clog2(NG) : 1;

    logic [NG*GW-1:0]   used_pad;
    logic [NG-1:0]      grp_any_reg;
    logic [NG-1:0]      grp_any_next;
    logic [GIW-1:0]     grp_low_reg  [NG];
    logic [GIW-1:0]     grp_low_next [NG];
    logic [GSW-1:0]     grp_sel;
    logic [GSW+GIW-1:0] lowest_wide;
    logic [AW-1:0]      lowest_reg;

    // Slots beyond the pool are padded as taken.
    always_comb begin
        used_pad = '1;
        used_pad[SLOT_COUNT-1:0] = in_use;
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_any_next[g] = 1'b0;
            grp_low_next[g] = '0;
            for (int b = GW - 1; b >= 0; b--) begin
                if (!used_pad[g*GW + b]) begin
                    grp_any_next[g] = 1'b1;
                    grp_low_next[g] = GIW'(b);
                end
            end
        end
    end

    always_comb begin
        grp_sel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                grp_sel = GSW'(g);
            end
        end
        lowest_wide = {grp_sel, grp_low_reg[grp_sel]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_any_reg <= '1;
            lowest_reg  <= '0;
            for (int g = 0; g < NG; g++) begin
                grp_low_reg[g] <= '0;
            end
        end else begin
            grp_any_reg <= grp_any_next;
            lowest_reg  <= lowest_wide[AW-1:0];
            for (int g = 0; g < NG; g++) begin
                grp_low_reg[g] <= grp_low_next[g];
            end
        end
    end

    assign lowest = lowest_reg;

endmodule

// File: hw/rtl/ldq_dpath.sv
// ============================================================================
// ldq_dpath: deque datapath
// Slot pool memories, end pointers, entry count, occupancy bits and the
// result register, stepped by strobes from the controller.
// ============================================================================
module ldq_dpath #(
    parameter int SLOT_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ldq_pkg::ctrl_cmd_t cmd,
    input  ldq_pkg::req_t      s_data,
    output ldq_pkg::rsp_t      m_data
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int VW = ldq_pkg::VALUE_W;
    localparam int HW = ldq_pkg::HANDLE_W;
    localparam int OW = ldq_pkg::COUNT_W;

    function automatic logic [AW-1:0] to_slot(input logic [HW-1:0] h);
        logic [AW+HW-1:0] w;
        w = {{AW{1'b0}}, h};
        return w[AW-1:0];
    endfunction

    function automatic logic [HW-1:0] to_handle(input logic [AW-1:0] s);
        logic [AW+HW-1:0] w;
        w = {{HW{1'b0}}, s};
        return w[HW-1:0];
    endfunction

    function automatic logic [OW-1:0] to_count(input logic [CW-1:0] c);
        logic [CW+OW-1:0] w;
        w = {{OW{1'b0}}, c};
        return w[OW-1:0];
    endfunction

    // Persistent deque state.
    logic [AW-1:0]         front_reg, front_next;
    logic [AW-1:0]         back_reg, back_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [SLOT_COUNT-1:0] in_use_reg, in_use_next;
    logic [VW-1:0]         fv_reg, fv_next;
    logic [VW-1:0]         bv_reg, bv_next;

    // Per-command working registers.
    ldq_pkg::req_t req_reg;
    logic [AW-1:0] node_reg;
    logic [VW-1:0] popped_reg;
    logic [AW-1:0] nbb_reg;
    logic [AW-1:0] nbf_reg;
    logic          at_front_reg, at_back_reg, empty_reg, hit_reg;
    ldq_pkg::rsp_t rsp_reg, rsp_next;

    logic [AW-1:0] node_sel;
    logic [AW-1:0] end_addr;
    logic          at_front, at_back, in_range;
    logic [AW-1:0] lowest;
    logic          is_push;

    // Memory ports.
    logic [VW-1:0] c_rd, c_wdata;
    logic [AW-1:0] c_raddr, c_waddr;
    logic          c_we;
    logic [AW-1:0] fl_rd, fl_waddr, fl_wdata;
    logic          fl_we;
    logic [AW-1:0] bl_rd, bl_waddr, bl_wdata;
    logic          bl_we;

    ldq_ram #(.WIDTH(VW), .DEPTH(SLOT_COUNT)) u_contents (
        .aclk    (aclk),
        .wr_en   (c_we),
        .wr_addr (c_waddr),
        .wr_data (c_wdata),
        .rd_en   (cmd.accept | cmd.resolve),
        .rd_addr (c_raddr),
        .rd_data (c_rd)
    );

    ldq_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_fwd_link (
        .aclk    (aclk),
        .wr_en   (fl_we),
        .wr_addr (fl_waddr),
        .wr_data (fl_wdata),
        .rd_en   (cmd.accept),
        .rd_addr (node_sel),
        .rd_data (fl_rd)
    );

    ldq_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_bwd_link (
        .aclk    (aclk),
        .wr_en   (bl_we),
        .wr_addr (bl_waddr),
        .wr_data (bl_wdata),
        .rd_en   (cmd.accept),
        .rd_addr (node_sel),
        .rd_data (bl_rd)
    );

    ldq_free_find #(.SLOT_COUNT(SLOT_COUNT)) u_free_find (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_use  (in_use_reg),
        .lowest  (lowest)
    );

    // The node a pop or removal works on is read as the command arrives.
    always_comb begin
        case (s_data.command)
            ldq_pkg::CMD_POP_BACK:  node_sel = back_reg;
            ldq_pkg::CMD_POP_FRONT: node_sel = front_reg;
            default:                node_sel = to_slot(s_data.handle);
        endcase
    end

    assign at_front = (node_reg == front_reg);
    assign at_back  = (node_reg == back_reg);
    assign in_range = (32'(req_reg.handle) < 32'(SLOT_COUNT));
    // The neighbour that becomes the new end, whose contents are fetched next.
    assign end_addr = at_front ? bl_rd : fl_rd;
    assign c_raddr  = cmd.accept ? node_sel : end_addr;
    assign is_push  = req_reg.command inside {ldq_pkg::CMD_PUSH_BACK, ldq_pkg::CMD_PUSH_FRONT};

    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        in_use_next = in_use_reg;
        fv_next     = fv_reg;
        bv_next     = bv_reg;
        c_we        = 1'b0;
        c_waddr     = lowest;
        c_wdata     = req_reg.value;
        fl_we       = 1'b0;
        fl_waddr    = lowest;
        fl_wdata    = back_reg;
        bl_we       = 1'b0;
        bl_waddr    = back_reg;
        bl_wdata    = lowest;
        rsp_next    = '0;
        rsp_next.status = ldq_pkg::ST_OK;

        if (is_push) begin
            if (count_reg == CW'(SLOT_COUNT)) begin
                rsp_next.status = ldq_pkg::ST_FULL;
            end else begin
                c_we                = cmd.commit;
                in_use_next[lowest] = 1'b1;
                count_next          = count_reg + CW'(1);
                rsp_next.new_handle = to_handle(lowest);
                if (count_reg == '0) begin
                    front_next = lowest;
                    back_next  = lowest;
                    fv_next    = req_reg.value;
                    bv_next    = req_reg.value;
                end else if (req_reg.command == ldq_pkg::CMD_PUSH_BACK) begin
                    fl_we     = cmd.commit;
                    bl_we     = cmd.commit;
                    back_next = lowest;
                    bv_next   = req_reg.value;
                end else begin
                    fl_we      = cmd.commit;
                    fl_waddr   = front_reg;
                    fl_wdata   = lowest;
                    bl_we      = cmd.commit;
                    bl_waddr   = lowest;
                    bl_wdata   = front_reg;
                    front_next = lowest;
                    fv_next    = req_reg.value;
                end
            end
        end else if (req_reg.command inside {ldq_pkg::CMD_POP_BACK, ldq_pkg::CMD_POP_FRONT,
                                             ldq_pkg::CMD_REMOVE}) begin
            if (!hit_reg) begin
                rsp_next.status = (req_reg.command == ldq_pkg::CMD_REMOVE) ?
                                  ldq_pkg::ST_BAD_HANDLE : ldq_pkg::ST_EMPTY;
            end else begin
                rsp_next.popped_value = popped_reg;
                in_use_next[node_reg] = 1'b0;
                count_next            = count_reg - CW'(1);
                if (empty_reg) begin
                    front_next = '0;
                    back_next  = '0;
                    fv_next    = '0;
                    bv_next    = '0;
                end else if (at_front_reg) begin
                    front_next = nbb_reg;
                    fv_next    = c_rd;
                end else if (at_back_reg) begin
                    back_next = nbf_reg;
                    bv_next   = c_rd;
                end else begin
                    // Interior node: splice its two neighbours together.
                    bl_we    = cmd.commit;
                    bl_waddr = nbf_reg;
                    bl_wdata = nbb_reg;
                    fl_we    = cmd.commit;
                    fl_waddr = nbb_reg;
                    fl_wdata = nbf_reg;
                end
            end
        end

        rsp_next.count       = to_count(count_next);
        rsp_next.front_value = (count_next != '0) ? fv_next : '0;
        rsp_next.back_value  = (count_next != '0) ? bv_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg  <= s_data;
            node_reg <= node_sel;
        end
        if (cmd.resolve) begin
            popped_reg   <= c_rd;
            nbb_reg      <= bl_rd;
            nbf_reg      <= fl_rd;
            at_front_reg <= at_front;
            at_back_reg  <= at_back;
            empty_reg    <= (count_reg <= CW'(1)) || (at_front && at_back);
            hit_reg      <= (req_reg.command == ldq_pkg::CMD_REMOVE) ?
                            (in_range && in_use_reg[node_reg]) : (count_reg != '0);
        end
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            in_use_reg <= '0;
            fv_reg     <= '0;
            bv_reg     <= '0;
        end else if (cmd.commit) begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            in_use_reg <= in_use_next;
            fv_reg     <= fv_next;
            bv_reg     <= bv_next;
        end
    end

    assign m_data = rsp_reg;

    a_count_matches_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(in_use_reg) == 32'(count_reg))
        else $error("entry count disagrees with the occupied slots");

    a_empty_ends_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (front_reg == '0 && back_reg == '0 &&
                               fv_reg == '0 && bv_reg == '0))
        else $error("empty deque still holds end pointers or values");

endmodule

// File: hw/rtl/ldq_ctrl.sv
// ============================================================================
// ldq_ctrl: deque controller
// Steps each command through arrival, link read and commit, and owns the
// handshake of both channels.
// ============================================================================
module ldq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output ldq_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LINK  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready     = (state_reg == ST_IDLE);
    assign out_free    = !m_valid_reg || m_ready;
    assign cmd.accept  = s_valid && s_ready;
    assign cmd.resolve = (state_reg == ST_LINK);
    assign cmd.commit  = (state_reg == ST_FETCH) && out_free;

    always_comb begin
        case (state_reg)
            ST_IDLE:  state_next = cmd.accept ? ST_LINK : ST_IDLE;
            ST_LINK:  state_next = ST_FETCH;
            ST_FETCH: state_next = cmd.commit ? ST_IDLE : ST_FETCH;
            default:  state_next = ST_IDLE;
        endcase

        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_to_link: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_LINK))
        else $error("accepted command did not move on to the link read");

    a_link_to_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LINK) |=> (state_reg == ST_FETCH))
        else $error("link read did not move on to the commit step");

    a_stall_holds_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH && m_valid_reg && !m_ready) |=>
            (state_reg == ST_FETCH && m_valid_reg))
        else $error("command committed over a result not yet taken");

endmodule

// File: hw/rtl/linked_deque_with_removal.sv
// ============================================================================
// linked_deque_with_removal: bounded deque with removal by handle
// A double-ended queue of 32-bit values kept as a doubly linked list in a
// pool of SLOT_COUNT slots.
// ============================================================================
// Each transfer on the s_ channel carries one command: push at the back or
// front, pop from the back or front, or remove the entry in a given slot.
// Every command yields exactly one transfer on the m_ channel, carrying a
// status, the slot handed to a pushed entry, the value taken out, the entry
// count and the values then at the front and back.
// A push claims the lowest-numbered free slot; the search for it runs in a
// two-level registered tree and is always settled by the time it is needed.
// The result is registered at the commit step, which follows the link read.
// A new command is taken only once the last has committed, since a pop or
// removal needs a chain of memory reads: the node's links are read first,
// then the contents of the neighbour that becomes the new end.
// s_ready is high whenever no command is in flight, also while an earlier
// result still waits in the output register. If the receiver stalls, the
// next command is worked through and then holds before its commit until the
// output register is free, so s_ready stays low until that result moves.
// After reset the deque is empty, all slots are free and no result is valid.
// Slot contents and link memories are not cleared; entries are only read
// once they have been written by a push.
// ============================================================================
module linked_deque_with_removal #(
    parameter int SLOT_COUNT = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ldq_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ldq_pkg::rsp_t m_data
);

    // Step strobes: accept on the input transfer, resolve while the link
    // data is in hand, commit when the result is loaded for the receiver.
    ldq_pkg::ctrl_cmd_t cmd;

    ldq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ldq_dpath #(.SLOT_COUNT(SLOT_COUNT)) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
